/* hdl/jhdc_pkg.sv */
// ----------------------------------------------------------------------------
// jhdc_pkg
// Shared types and constants for the JPEG header dimension check.
// ----------------------------------------------------------------------------
package jhdc_pkg;

   localparam int POSITION_BITS = 24;
   localparam int LENGTH_BITS   = 24;
   localparam int SIDE_BITS     = 16;
   // wide enough for position/length sums without overflow
   localparam int ARITH_BITS    =
      ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 2;

   localparam logic [SIDE_BITS-1:0] SIDE_RESET = 16'd256;

   localparam logic [7:0] BYTE_PREFIX = 8'hFF;
   localparam logic [7:0] MARK_SOI    = 8'hD8;
   localparam logic [7:0] MARK_EOI    = 8'hD9;
   localparam logic [7:0] MARK_SOS    = 8'hDA;
   localparam logic [7:0] MARK_TEM    = 8'h01;
   localparam logic [7:0] MARK_RST0   = 8'hD0;
   localparam logic [7:0] MARK_RST7   = 8'hD7;
   localparam logic [7:0] MARK_SOF_LO = 8'hC0;
   localparam logic [7:0] MARK_SOF_HI = 8'hCF;
   localparam logic [7:0] MARK_DHT    = 8'hC4;
   localparam logic [7:0] MARK_JPG    = 8'hC8;
   localparam logic [7:0] MARK_DAC    = 8'hCC;
   localparam logic [7:0] PRECISION_8 = 8'd8;
   localparam logic [15:0] SEG_MIN_LEN = 16'd2;
   localparam logic [15:0] SOF_MIN_LEN = 16'd8;

   typedef enum logic [3:0] {
      PH_PREFIX = 4'd0,
      PH_FILL   = 4'd1,
      PH_LEN_HI = 4'd2,
      PH_LEN_LO = 4'd3,
      PH_SKIP   = 4'd4,
      PH_SOF_P  = 4'd5,
      PH_SOF_H1 = 4'd6,
      PH_SOF_H2 = 4'd7,
      PH_SOF_W1 = 4'd8,
      PH_SOF_W2 = 4'd9,
      PH_DONE   = 4'd10
   } phase_type;

   typedef enum logic [1:0] {
      VD_NONE     = 2'd0,
      VD_ACCEPT   = 2'd1,
      VD_MISMATCH = 2'd2
   } verdict_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED   = 2'd0,
      ST_INCOMPLETE = 2'd1,
      ST_MISMATCH   = 2'd2,
      ST_INVALID    = 2'd3
   } status_type;

   function automatic logic is_sof(input logic [7:0] m);
      return (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI) &&
             (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
   endfunction

endpackage

/* hdl/jpeg_header_dimension_check_top.sv */
// ----------------------------------------------------------------------------
// jpeg_header_dimension_check_top
// Streams a JPEG image byte by byte, walks its marker segments and reports
// one status per image.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one image byte per transfer, with the image byte count and a
//            flag on the final byte. One byte is taken every cycle unless req_ready drops (see Stall).
//   rsp_*  : one status per image, produced only for the final byte:
//            0 accepted, 1 not a complete JPEG, 2 size/precision mismatch,
//            3 invalid header.
//   csr_*  : writes expected_side (required height and width). Write only
//            while no image is in flight. csr_ready is always high.
// Order: a byte is registered in the input stage on transfer and evaluated
//   there; the status of the final byte is registered in the result stage
//   when that byte is evaluated, and can transfer from there.
// Throughput: one byte per cycle, set by the walk update, while no final byte is held (see Stall).
// Stall: a waiting status holds in the output register; bytes keep flowing
//   until the next final byte reaches the evaluation stage, which then holds
//   (and req_ready drops) until the pending status is transferred.
// Reset: clears the walk state and both stages; expected_side returns to 256.
// ----------------------------------------------------------------------------
module jpeg_header_dimension_check_top
   import jhdc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   input  logic [LENGTH_BITS-1:0]   req_total_length,
   input  logic                     req_last_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [SIDE_BITS-1:0]     csr_expected_side
);

   // input stage
   logic                   in_valid_ff;
   logic [7:0]             in_byte_ff;
   logic [LENGTH_BITS-1:0] in_len_ff;
   logic                   in_last_ff;

   // walk state
   logic [SIDE_BITS-1:0]     side_ff;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   phase_type                phase_ff, phase_in;
   logic [15:0]              offset_ff, offset_in;
   logic [15:0]              seglen_ff, seglen_in;
   logic [7:0]               marker_ff, marker_in;
   logic [7:0]               high_ff, high_in;
   logic [7:0]               prev_ff, prev_in;
   logic                     start_ok_ff, start_ok_in;
   verdict_type              verdict_ff, verdict_in;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic advance;
   logic [ARITH_BITS-1:0] pe, ne, size_e;
   logic [15:0] size;
   logic        complete;

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   assign pe     = ARITH_BITS'(pos_ff);
   assign ne     = ARITH_BITS'(in_len_ff);
   assign size   = {high_ff, in_byte_ff};
   assign size_e = ARITH_BITS'(size);

   always_comb begin
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      offset_in     = offset_ff;
      seglen_in     = seglen_ff;
      marker_in     = marker_ff;
      high_in       = high_ff;
      prev_in       = prev_ff;
      start_ok_in   = start_ok_ff;
      verdict_in    = verdict_ff;
      complete      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;

      if (advance) begin
         if (pe == ARITH_BITS'(1) && prev_ff == BYTE_PREFIX && in_byte_ff == MARK_SOI) begin
            start_ok_in = 1'b1;
         end

         if (pe >= ARITH_BITS'(2) && phase_ff != PH_DONE) begin
            if (pe >= ne) begin
               phase_in = PH_DONE;
            end else begin
               case (phase_ff)
                  PH_PREFIX: begin
                     if (!(pe + ARITH_BITS'(3) < ne) || in_byte_ff != BYTE_PREFIX)
                        phase_in = PH_DONE;
                     else
                        phase_in = PH_FILL;
                  end
                  PH_FILL: begin
                     if (in_byte_ff != BYTE_PREFIX) begin
                        marker_in = in_byte_ff;
                        if (in_byte_ff == MARK_SOS || in_byte_ff == MARK_EOI)
                           phase_in = PH_DONE;
                        else if (in_byte_ff == MARK_TEM ||
                                 (in_byte_ff >= MARK_RST0 && in_byte_ff <= MARK_RST7))
                           phase_in = PH_PREFIX;
                        else if (pe + ARITH_BITS'(3) > ne)
                           phase_in = PH_DONE;
                        else
                           phase_in = PH_LEN_HI;
                     end
                  end
                  PH_LEN_HI: begin
                     high_in  = in_byte_ff;
                     phase_in = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     // segment may not run past the image end
                     if (size < SEG_MIN_LEN || size_e + pe > ne + ARITH_BITS'(1)) begin
                        phase_in = PH_DONE;
                     end else begin
                        seglen_in = size;
                        if (is_sof(marker_ff)) begin
                           if (size < SOF_MIN_LEN) begin
                              verdict_in = VD_MISMATCH;
                              phase_in   = PH_DONE;
                           end else begin
                              phase_in = PH_SOF_P;
                           end
                        end else if (size == SEG_MIN_LEN) begin
                           phase_in = PH_PREFIX;
                        end else begin
                           offset_in = size - SEG_MIN_LEN;
                           phase_in  = PH_SKIP;
                        end
                     end
                  end
                  PH_SKIP: begin
                     offset_in = offset_ff - 16'd1;
                     if (offset_ff == 16'd1) phase_in = PH_PREFIX;
                  end
                  PH_SOF_P: begin
                     if (in_byte_ff != PRECISION_8) begin
                        verdict_in = VD_MISMATCH;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_SOF_H1;
                     end
                  end
                  PH_SOF_H1: begin
                     high_in  = in_byte_ff;
                     phase_in = PH_SOF_H2;
                  end
                  PH_SOF_H2: begin
                     if (size != side_ff) begin
                        verdict_in = VD_MISMATCH;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_SOF_W1;
                     end
                  end
                  PH_SOF_W1: begin
                     high_in  = in_byte_ff;
                     phase_in = PH_SOF_W2;
                  end
                  PH_SOF_W2: begin
                     verdict_in = (size != side_ff) ? VD_MISMATCH : VD_ACCEPT;
                     phase_in   = PH_DONE;
                  end
                  default: begin
                     phase_in = PH_DONE;
                  end
               endcase
            end
         end

         if (in_last_ff) begin
            complete = (ne >= ARITH_BITS'(4)) && (pe + ARITH_BITS'(1) == ne) &&
                       start_ok_in && prev_ff == BYTE_PREFIX && in_byte_ff == MARK_EOI;
            rsp_valid_in = 1'b1;
            if (!complete)                  rsp_status_in = ST_INCOMPLETE;
            else if (verdict_in == VD_ACCEPT)   rsp_status_in = ST_ACCEPTED;
            else if (verdict_in == VD_MISMATCH) rsp_status_in = ST_MISMATCH;
            else                            rsp_status_in = ST_INVALID;
            // per-image state back to reset
            pos_in      = '0;
            phase_in    = PH_PREFIX;
            offset_in   = '0;
            seglen_in   = '0;
            marker_in   = '0;
            high_in     = '0;
            prev_in     = '0;
            start_ok_in = 1'b0;
            verdict_in  = VD_NONE;
         end else begin
            prev_in = in_byte_ff;
            if (pos_ff != '1) pos_in = pos_ff + 1'b1;   // saturate
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         side_ff       <= SIDE_RESET;
         pos_ff        <= '0;
         phase_ff      <= PH_PREFIX;
         offset_ff     <= '0;
         seglen_ff     <= '0;
         marker_ff     <= '0;
         high_ff       <= '0;
         prev_ff       <= '0;
         start_ok_ff   <= 1'b0;
         verdict_ff    <= VD_NONE;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_ACCEPTED;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) side_ff <= csr_expected_side;
         pos_ff        <= pos_in;
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         seglen_ff     <= seglen_in;
         marker_ff     <= marker_in;
         high_ff       <= high_in;
         prev_ff       <= prev_in;
         start_ok_ff   <= start_ok_in;
         verdict_ff    <= verdict_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_len_ff  <= req_total_length;
         in_last_ff <= req_last_byte;
      end
   end

`ifndef SYNTHESIS
   a_verdict_ends_walk: assert property (@(posedge clock) disable iff (reset)
      (verdict_ff != VD_NONE) |-> (phase_ff == PH_DONE))
      else $error("verdict set while walk still running");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (offset_ff != 16'd0))
      else $error("skip phase with zero remaining bytes");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (pos_ff == '0 && phase_ff == PH_PREFIX && !start_ok_ff))
      else $error("image state not cleared after final byte");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("status produced without a final byte");
`endif

endmodule

/* test/tb_jpeg_header_dimension_check_top.sv */
// ----------------------------------------------------------------------------
// tb_jpeg_header_dimension_check_top
// Streams JPEG-like byte sequences into the header checker and compares every
// per-image status with a cycle-free model of the marker walk. A short table
// of hand-built images comes first, then random clean, damaged and noise
// images under changing sender/receiver stall patterns and side settings.
// ----------------------------------------------------------------------------
module tb_jpeg_header_dimension_check_top
   import jhdc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES   = 6;
   localparam int LONG_HOLD      = 400;
   localparam int PHASE_BYTES    = 420;
   localparam int MIN_IMAGES     = 10;
   localparam int DIRECTED_COUNT = 29;

   typedef enum int {IMG_CLEAN, IMG_BROKEN, IMG_NOISE} image_kind_type;

   typedef struct packed {
      logic [7:0]  data;
      logic [23:0] total;
      logic        last;
      logic        fixed;   // status typed in below
      status_type  want;
   } directed_row_type;

   // 1-byte image, minimal SOI/EOI, accepted 256x256 SOF, short SOF segment
   localparam directed_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      '{8'hFF, 24'hFFFFFF, 1'b1, 1'b1, ST_INCOMPLETE},
      '{8'hFF, 24'd4,  1'b0, 1'b0, ST_ACCEPTED},
      '{8'hD8, 24'd4,  1'b0, 1'b0, ST_ACCEPTED},
      '{8'hFF, 24'd4,  1'b0, 1'b0, ST_ACCEPTED},
      '{8'hD9, 24'd4,  1'b1, 1'b1, ST_INVALID},
      '{8'hFF, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hD8, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hFF, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hC0, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h00, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h08, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h08, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h01, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h00, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h01, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h00, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hFF, 24'd13, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hD9, 24'd13, 1'b1, 1'b1, ST_ACCEPTED},
      '{8'hFF, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hD8, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hFF, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hC1, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h00, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h07, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h08, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h00, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'h00, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hFF, 24'd11, 1'b0, 1'b0, ST_ACCEPTED},
      '{8'hD9, 24'd11, 1'b1, 1'b1, ST_MISMATCH}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [7:0]             req_data_byte;
   logic [LENGTH_BITS-1:0] req_total_length;
   logic                   req_last_byte;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [1:0]             rsp_status;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [SIDE_BITS-1:0]   csr_expected_side;

   // walk model state
   logic [SIDE_BITS-1:0]     side_cfg;
   logic [POSITION_BITS-1:0] pos;
   phase_type                phase;
   logic [15:0]              skip_left;
   logic [7:0]               marker;
   logic [7:0]               hi_byte;
   logic [7:0]               prev_byte;
   logic                     soi_seen;
   verdict_type              verdict;

   status_type  pending_status[$];
   logic [7:0]  image_bytes[$];
   int          bytes_sent;
   int          mismatch_count;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_request;
   int          hold_left;

   jpeg_header_dimension_check_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_total_length  (req_total_length),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_expected_side (csr_expected_side)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- model
   task automatic clear_image_state();
      pos       = '0;
      phase     = PH_PREFIX;
      skip_left = '0;
      marker    = '0;
      hi_byte   = '0;
      prev_byte = '0;
      soi_seen  = 1'b0;
      verdict   = VD_NONE;
   endtask

   task automatic advance_walk(input logic [7:0] b, input logic [31:0] p,
                               input logic [31:0] n);
      logic [31:0] seg_size;
      logic        frame_marker;
      if (phase >= PH_DONE) return;
      if (p >= n) begin
         phase = PH_DONE;
         return;
      end
      case (phase)
         PH_PREFIX:
            phase = (p + 3 < n && b == BYTE_PREFIX) ? PH_FILL : PH_DONE;
         PH_FILL: begin
            if (b != BYTE_PREFIX) begin
               marker = b;
               if (b == MARK_SOS || b == MARK_EOI) phase = PH_DONE;
               else if (b == MARK_TEM || (b >= MARK_RST0 && b <= MARK_RST7))
                  phase = PH_PREFIX;
               else if (p + 3 > n) phase = PH_DONE;
               else phase = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            hi_byte = b;
            phase   = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            seg_size     = {16'd0, hi_byte, b};
            frame_marker = marker >= MARK_SOF_LO && marker <= MARK_SOF_HI &&
                           marker != MARK_DHT && marker != MARK_JPG &&
                           marker != MARK_DAC;
            if (seg_size < 2 || seg_size > n - (p - 1)) begin
               phase = PH_DONE;
            end else if (frame_marker) begin
               if (seg_size < 8) begin
                  verdict = VD_MISMATCH;
                  phase   = PH_DONE;
               end else begin
                  phase = PH_SOF_P;
               end
            end else if (seg_size == 2) begin
               phase = PH_PREFIX;
            end else begin
               skip_left = 16'(seg_size - 2);
               phase     = PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 16'd0) phase = PH_PREFIX;
         end
         PH_SOF_P: begin
            if (b != PRECISION_8) begin
               verdict = VD_MISMATCH;
               phase   = PH_DONE;
            end else begin
               phase = PH_SOF_H1;
            end
         end
         PH_SOF_H1, PH_SOF_W1: begin
            hi_byte = b;
            phase   = phase_type'(phase + 4'd1);
         end
         PH_SOF_H2: begin
            if ({hi_byte, b} != side_cfg) begin
               verdict = VD_MISMATCH;
               phase   = PH_DONE;
            end else begin
               phase = PH_SOF_W1;
            end
         end
         PH_SOF_W2: begin
            verdict = ({hi_byte, b} == side_cfg) ? VD_ACCEPT : VD_MISMATCH;
            phase   = PH_DONE;
         end
         default: phase = PH_DONE;
      endcase
   endtask

   // one accepted byte; a status comes out only on the final byte
   task automatic track_byte(input logic [7:0] b, input logic [23:0] n,
                             input logic last, output bit has_status,
                             output status_type st);
      logic [31:0] p;
      bit          whole;
      p  = 32'(pos);
      st = ST_INVALID;
      if (p == 1 && prev_byte == BYTE_PREFIX && b == MARK_SOI) soi_seen = 1'b1;
      if (p >= 2) advance_walk(b, p, 32'(n));
      has_status = last;
      if (last) begin
         whole = n >= 4 && p + 1 == 32'(n) && soi_seen &&
                 prev_byte == BYTE_PREFIX && b == MARK_EOI;
         if (!whole) st = ST_INCOMPLETE;
         else if (verdict == VD_ACCEPT) st = ST_ACCEPTED;
         else if (verdict == VD_MISMATCH) st = ST_MISMATCH;
         clear_image_state();
      end else begin
         prev_byte = b;
         if (pos != '1) pos = pos + 1'b1;
      end
   endtask

   // -------------------------------------------------------------- drivers
   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(input logic [7:0] b, input logic [23:0] n,
                            input logic last, input logic fixed,
                            input status_type want);
      bit         has_status;
      status_type st;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= b;
      req_total_length <= n;
      req_last_byte    <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_byte(b, n, last, has_status, st);
      if (has_status) pending_status.push_back(fixed ? want : st);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_side(input logic [SIDE_BITS-1:0] value);
      csr_valid         <= 1'b1;
      csr_expected_side <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      side_cfg = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------- image builders
   task automatic add_marker_header(input logic [7:0] m, input logic [15:0] len);
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 2)) image_bytes.push_back(BYTE_PREFIX);
      image_bytes.push_back(BYTE_PREFIX);
      image_bytes.push_back(m);
      image_bytes.push_back(len[15:8]);
      image_bytes.push_back(len[7:0]);
   endtask

   task automatic add_frame_header();
      logic [7:0]  m;
      logic [15:0] height;
      logic [15:0] width;
      int          extra;
      m = MARK_SOF_LO + 8'($urandom_range(15));
      if (m == MARK_DHT || m == MARK_JPG || m == MARK_DAC) m = m + 8'd1;
      extra  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      height = ($urandom_range(7) == 0) ? 16'($urandom_range(16'hFFFF)) : side_cfg;
      width  = ($urandom_range(7) == 0) ? 16'($urandom_range(16'hFFFF)) : side_cfg;
      add_marker_header(m, 16'(7 + extra));
      image_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                      : PRECISION_8);
      image_bytes.push_back(height[15:8]);
      image_bytes.push_back(height[7:0]);
      image_bytes.push_back(width[15:8]);
      image_bytes.push_back(width[7:0]);
      repeat (extra) image_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic add_other_segment();
      logic [7:0] m;
      int         body;
      if ($urandom_range(9) < 3) begin
         image_bytes.push_back(BYTE_PREFIX);
         image_bytes.push_back(($urandom_range(7) == 0) ? MARK_TEM
                               : MARK_RST0 + 8'($urandom_range(7)));
         return;
      end
      case ($urandom_range(5))
         0: m = 8'hE0 + 8'($urandom_range(15));
         1: m = 8'hDB;
         2: m = MARK_DHT;
         3: m = $urandom_range(1) ? MARK_JPG : MARK_DAC;
         4: m = 8'hFE;
         default: m = 8'hDD;
      endcase
      body = $urandom_range(6);
      case ($urandom_range(15))
         0: add_marker_header(m, 16'($urandom_range(1)));        // length below 2
         1: add_marker_header(m, 16'($urandom_range(16'hFFFF))); // runs off the end
         default: add_marker_header(m, 16'(body + 2));
      endcase
      repeat (body) image_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic build_image(input bit damaged);
      int segs;
      int frame_at;
      int k;
      int cnt;
      image_bytes.delete();
      image_bytes.push_back(BYTE_PREFIX);
      image_bytes.push_back(MARK_SOI);
      segs     = $urandom_range(3);
      frame_at = ($urandom_range(6) == 0) ? -1 : $urandom_range(segs);
      for (k = 0; k <= segs; k++) begin
         if (k == frame_at) add_frame_header();
         if (k < segs) add_other_segment();
      end
      image_bytes.push_back(BYTE_PREFIX);
      image_bytes.push_back(MARK_SOS);
      repeat ($urandom_range(6)) image_bytes.push_back(8'($urandom_range(255)));
      image_bytes.push_back(BYTE_PREFIX);
      image_bytes.push_back(MARK_EOI);
      if (damaged) begin
         cnt = image_bytes.size();
         case ($urandom_range(3))
            0: image_bytes[$urandom_range(cnt - 1)] = 8'($urandom_range(255));
            1: image_bytes.delete($urandom_range(cnt - 1));
            2: image_bytes.insert($urandom_range(cnt), 8'($urandom_range(255)));
            default: begin
               image_bytes[$urandom_range(cnt - 1)] = 8'($urandom_range(255));
               image_bytes[$urandom_range(cnt - 1)] = 8'($urandom_range(255));
            end
         endcase
      end
   endtask

   task automatic send_image(input image_kind_type kind);
      logic [23:0] n;
      logic [23:0] n_now;
      logic        fin;
      int          cnt;
      int          idx;
      if (kind == IMG_NOISE) begin
         image_bytes.delete();
         repeat ($urandom_range(1, 12)) image_bytes.push_back(8'($urandom_range(255)));
      end else begin
         build_image(kind == IMG_BROKEN);
      end
      cnt = image_bytes.size();
      n   = 24'(cnt);
      if (kind != IMG_CLEAN && $urandom_range(1) == 1)
         n = ($urandom_range(2) == 0) ? 24'($urandom_range(24'hFFFFFF))
                                      : 24'(cnt + $urandom_range(4) - 2);
      for (idx = 0; idx < cnt; idx++) begin
         // damaged images may carry a wrong count on single bytes
         n_now = (kind == IMG_BROKEN && $urandom_range(15) == 0)
                 ? 24'($urandom_range(24'hFFFFFF)) : n;
         fin   = (idx == cnt - 1) || (kind == IMG_NOISE && $urandom_range(5) == 0);
         send_byte(image_bytes[idx], n_now, fin, 1'b0, ST_ACCEPTED);
      end
   endtask

   task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
      int first;
      int images;
      int r;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      first  = bytes_sent;
      images = 0;
      while (bytes_sent - first < PHASE_BYTES || images < MIN_IMAGES) begin
         r = $urandom_range(99);
         if (r < 10) send_image(IMG_NOISE);
         else if (r < 30) send_image(IMG_BROKEN);
         else send_image(IMG_CLEAN);
         images++;
      end
   endtask

   // ------------------------------------------------------------- receiver
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            rsp_ready   <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status.size() == 0) begin
            $display("%0t: unexpected status transfer, expected none, got %0d",
                     $time, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_status.pop_front();
            if (rsp_status !== want) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // ----------------------------------------------------------------- main
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_total_length  = '0;
      req_last_byte     = 1'b0;
      csr_valid         = 1'b0;
      csr_expected_side = '0;
      hold_request      = 1'b0;
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      bytes_sent        = 0;
      mismatch_count    = 0;
      side_cfg          = SIDE_RESET;
      clear_image_state();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].total,
                   DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].fixed,
                   DIRECTED_ROWS[i].want);
      wait_idle();

      write_side(16'hFFFF);
      run_phase(16, 82);

      // receiver stalls while the sender keeps offering back-to-back images
      send_idle_pct = 0;
      hold_request  = 1'b1;
      repeat (6) send_image(IMG_CLEAN);
      wait_idle();

      write_side(16'h0000);
      run_phase(82, 16);
      wait_idle();

      write_side(16'($urandom_range(16'hFFFF)));
      run_phase(0, 0);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
